FILE: rtl/core/tpi_pkg.sv
// Shared types and constants of the turtle path interpreter.
// Holds command and result codes, register indexes, reset values and the trig table.
// Depends on nothing.
package tpi_pkg;

    localparam int SYMBOL_W   = 8;
    localparam int COORD_W    = 18;
    localparam int KIND_W     = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [SYMBOL_W-1:0] SYM_FORWARD = 8'h46;
    localparam logic [SYMBOL_W-1:0] SYM_PLUS    = 8'h2B;
    localparam logic [SYMBOL_W-1:0] SYM_MINUS   = 8'h2D;
    localparam logic [SYMBOL_W-1:0] SYM_PUSH    = 8'h5B;
    localparam logic [SYMBOL_W-1:0] SYM_POP     = 8'h5D;

    localparam logic [KIND_W-1:0] KIND_SEGMENT   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_OVERFLOW  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_UNDERFLOW = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_STEP_LENGTH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TURN_UNITS    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_START_HEADING = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_START_X       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_START_Y       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT_X       = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT_Y       = 3'd6;

    localparam logic [7:0]  RST_STEP_LENGTH   = 8'd5;
    localparam logic [3:0]  RST_TURN_UNITS    = 4'd1;
    localparam logic [3:0]  RST_START_HEADING = 4'd10;
    localparam logic [9:0]  RST_START_X       = 10'd0;
    localparam logic [9:0]  RST_START_Y       = 10'd310;
    localparam logic [10:0] RST_LIMIT_X       = 11'd240;
    localparam logic [10:0] RST_LIMIT_Y       = 11'd320;

    localparam logic [10:0] POS_LIMIT  = 11'd1024;
    localparam logic [3:0]  NUM_DIRS   = 4'd12;
    localparam logic [3:0]  SIN_OFFSET = 4'd9;
    localparam int          COS30_Q14  = 14189;
    localparam int          Q14_BITS   = 14;

    localparam logic [2:0] OP_NOP      = 3'd0;
    localparam logic [2:0] OP_FORWARD  = 3'd1;
    localparam logic [2:0] OP_TURN_POS = 3'd2;
    localparam logic [2:0] OP_TURN_NEG = 3'd3;
    localparam logic [2:0] OP_PUSH     = 3'd4;
    localparam logic [2:0] OP_POP      = 3'd5;

    localparam logic [1:0] MAG_ZERO = 2'd0;
    localparam logic [1:0] MAG_HALF = 2'd1;
    localparam logic [1:0] MAG_C30  = 2'd2;
    localparam logic [1:0] MAG_ONE  = 2'd3;

    typedef struct packed {
        logic       first;
        logic [2:0] op;
    } cmd_t;

    typedef struct packed {
        logic [7:0]  step_length;
        logic [3:0]  turn_units;
        logic [3:0]  start_heading;
        logic [9:0]  start_x;
        logic [9:0]  start_y;
        logic [10:0] limit_x;
        logic [10:0] limit_y;
    } cfg_t;

    typedef struct packed {
        logic       neg;
        logic [1:0] mag;
    } trig_t;

    function automatic logic [3:0] mod12(input logic [3:0] v);
        mod12 = (v >= NUM_DIRS) ? v - NUM_DIRS : v;
    endfunction

    // Cosine of k times 30 degrees as a sign and a magnitude class.
    function automatic trig_t cos_class(input logic [3:0] k);
        case (k)
            4'd0:    cos_class = '{neg: 1'b0, mag: MAG_ONE};
            4'd1:    cos_class = '{neg: 1'b0, mag: MAG_C30};
            4'd2:    cos_class = '{neg: 1'b0, mag: MAG_HALF};
            4'd3:    cos_class = '{neg: 1'b0, mag: MAG_ZERO};
            4'd4:    cos_class = '{neg: 1'b1, mag: MAG_HALF};
            4'd5:    cos_class = '{neg: 1'b1, mag: MAG_C30};
            4'd6:    cos_class = '{neg: 1'b1, mag: MAG_ONE};
            4'd7:    cos_class = '{neg: 1'b1, mag: MAG_C30};
            4'd8:    cos_class = '{neg: 1'b1, mag: MAG_HALF};
            4'd9:    cos_class = '{neg: 1'b0, mag: MAG_ZERO};
            4'd10:   cos_class = '{neg: 1'b0, mag: MAG_HALF};
            4'd11:   cos_class = '{neg: 1'b0, mag: MAG_C30};
            default: cos_class = '{neg: 1'b0, mag: MAG_ZERO};
        endcase
    endfunction

endpackage

FILE: rtl/core/tpi_front.sv
// Front end of the turtle path interpreter: takes input beats and decodes the command byte.
// Uses tpi_pkg; feeds tpi_queue.
module tpi_front
    import tpi_pkg::*;
(
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                in_first,
    input  logic [SYMBOL_W-1:0] in_symbol,
    output logic                push_valid,
    output cmd_t                push_cmd,
    input  logic                push_ready
);

    logic [2:0] op;

    always_comb
    begin
        case (in_symbol)
            SYM_FORWARD: op = OP_FORWARD;
            SYM_PLUS:    op = OP_TURN_POS;
            SYM_MINUS:   op = OP_TURN_NEG;
            SYM_PUSH:    op = OP_PUSH;
            SYM_POP:     op = OP_POP;
            default:     op = OP_NOP;
        endcase
    end

    // Bytes that neither act nor restart the turtle never enter the queue.
    assign in_ready       = push_ready;
    assign push_cmd.first = in_first;
    assign push_cmd.op    = op;
    assign push_valid     = in_valid && (in_first || (op != OP_NOP));

endmodule

FILE: rtl/core/tpi_queue.sv
// Two-entry command queue between the front end and the execution unit.
// Uses tpi_pkg for the command type.
module tpi_queue
    import tpi_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    input  cmd_t in_cmd,
    output logic in_ready,
    output logic out_valid,
    output cmd_t out_cmd,
    input  logic out_pop
);

    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    cmd_t       slot_reg [QUEUE_DEPTH];
    logic       do_wr;
    logic       do_rd;

    assign in_ready  = (count_reg != 2'(QUEUE_DEPTH));
    assign out_valid = (count_reg != 2'd0);
    assign out_cmd   = slot_reg[rd_ptr_reg];
    assign do_wr     = in_valid && in_ready;
    assign do_rd     = out_pop && out_valid;

    always_comb
    begin
        count_next = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (!do_wr && do_rd)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_wr)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

FILE: rtl/core/tpi_back.sv
// Execution unit: turtle state, branch stack memory and the registered result stage.
// Uses tpi_pkg; takes commands from tpi_queue.
module tpi_back
    import tpi_pkg::*;
#(
    parameter int STACK_DEPTH = 1024,
    parameter int FRAC_BITS   = 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  cfg_t                  cfg,
    input  logic [FRAC_BITS+7:0]  c30,
    input  logic                  cmd_valid,
    input  cmd_t                  cmd,
    output logic                  cmd_pop,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [KIND_W-1:0]     out_kind,
    output logic [COORD_W-1:0]    out_from_x,
    output logic [COORD_W-1:0]    out_from_y,
    output logic [COORD_W-1:0]    out_to_x,
    output logic [COORD_W-1:0]    out_to_y
);

    localparam int PW = 10 + FRAC_BITS;
    localparam int DW = 8 + FRAC_BITS;
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);
    localparam int EW = 2 * PW + 4;

    function automatic logic [COORD_W-1:0] to_coord(input logic [PW-1:0] v);
        logic [PW+COORD_W-1:0] w;
        w = {{COORD_W{1'b0}}, v};
        return w[COORD_W-1:0];
    endfunction

    function automatic logic signed [PW+1:0] delta_of(input trig_t t, input logic [7:0] step,
                                                      input logic [DW-1:0] c30_mag);
        logic [DW-1:0]    mag;
        logic [PW+1:0]    ext;
        case (t.mag)
            MAG_ZERO: mag = '0;
            MAG_HALF: mag = DW'(step) << (FRAC_BITS - 1);
            MAG_C30:  mag = c30_mag;
            MAG_ONE:  mag = DW'(step) << FRAC_BITS;
            default:  mag = '0;
        endcase
        ext = (PW + 2)'(mag);
        return t.neg ? -$signed(ext) : $signed(ext);
    endfunction

    logic [PW-1:0]  pos_x_reg, pos_x_next;
    logic [PW-1:0]  pos_y_reg, pos_y_next;
    logic [3:0]     head_reg, head_next;
    logic [CW-1:0]  top_reg, top_next;
    logic [EW-1:0]  tos_reg;
    logic           tos_sel_reg;
    logic [EW-1:0]  rd_data_reg;
    logic [EW-1:0]  stack_mem [STACK_DEPTH];

    logic                   out_valid_reg;
    logic [KIND_W-1:0]      kind_reg;
    logic [COORD_W-1:0]     from_x_reg, from_y_reg, to_x_reg, to_y_reg;

    logic                   exec;
    logic [PW-1:0]          cur_x, cur_y;
    logic [3:0]             cur_h;
    logic [CW-1:0]          cur_n;
    logic [EW-1:0]          tos;
    logic [EW-1:0]          cur_entry;
    logic [4:0]             sin_sum, h_plus, h_minus;
    logic [3:0]             sin_idx;
    logic signed [PW+1:0]   dx, dy, nx, ny;
    logic [10:0]            bnd_w, bnd_h;
    logic [PW:0]            bound_x, bound_y;
    logic                   in_bounds;
    logic                   is_full, is_empty;
    logic                   push_ok, pop_ok;
    logic [AW-1:0]          wr_addr, rd_addr;
    logic [CW-1:0]          rd_pos;
    logic                   res_valid;
    logic [KIND_W-1:0]      res_kind;
    logic [COORD_W-1:0]     res_from_x, res_from_y, res_to_x, res_to_y;

    assign exec    = cmd_valid && (!out_valid_reg || out_ready);
    assign cmd_pop = exec;

    // A restart puts the turtle home and empties the stack before the command acts.
    assign cur_x = cmd.first ? (PW'(cfg.start_x) << FRAC_BITS) : pos_x_reg;
    assign cur_y = cmd.first ? (PW'(cfg.start_y) << FRAC_BITS) : pos_y_reg;
    assign cur_h = cmd.first ? cfg.start_heading : head_reg;
    assign cur_n = cmd.first ? '0 : top_reg;

    // The top stack entry lives in a register, so pops can run back to back.
    assign tos       = tos_sel_reg ? rd_data_reg : tos_reg;
    assign cur_entry = {cur_x, cur_y, cur_h};

    assign sin_sum = {1'b0, cur_h} + {1'b0, SIN_OFFSET};
    assign sin_idx = (sin_sum >= {1'b0, NUM_DIRS}) ? 4'(sin_sum - {1'b0, NUM_DIRS})
                                                   : sin_sum[3:0];
    assign dx = delta_of(cos_class(cur_h), cfg.step_length, c30);
    assign dy = delta_of(cos_class(sin_idx), cfg.step_length, c30);
    assign nx = $signed({2'b00, cur_x}) + dx;
    assign ny = $signed({2'b00, cur_y}) + dy;

    assign bnd_w   = (cfg.limit_x > POS_LIMIT) ? POS_LIMIT : cfg.limit_x;
    assign bnd_h   = (cfg.limit_y > POS_LIMIT) ? POS_LIMIT : cfg.limit_y;
    assign bound_x = (PW + 1)'(bnd_w) << FRAC_BITS;
    assign bound_y = (PW + 1)'(bnd_h) << FRAC_BITS;
    assign in_bounds = !nx[PW+1] && (nx[PW:0] < bound_x) &&
                       !ny[PW+1] && (ny[PW:0] < bound_y);

    assign h_plus  = {1'b0, cur_h} + {1'b0, cfg.turn_units};
    assign h_minus = {1'b0, cur_h} + {1'b0, NUM_DIRS} - {1'b0, cfg.turn_units};

    assign is_full  = (cur_n == CW'(STACK_DEPTH));
    assign is_empty = (cur_n == '0);
    assign push_ok  = exec && (cmd.op == OP_PUSH) && !is_full;
    assign pop_ok   = exec && (cmd.op == OP_POP) && !is_empty;
    assign wr_addr  = cur_n[AW-1:0];
    assign rd_pos   = cur_n - CW'(2);
    assign rd_addr  = rd_pos[AW-1:0];

    always_comb
    begin
        pos_x_next = pos_x_reg;
        pos_y_next = pos_y_reg;
        head_next  = head_reg;
        top_next   = top_reg;
        res_valid  = 1'b0;
        res_kind   = KIND_SEGMENT;
        res_from_x = '0;
        res_from_y = '0;
        res_to_x   = '0;
        res_to_y   = '0;
        if (exec)
        begin
            pos_x_next = cur_x;
            pos_y_next = cur_y;
            head_next  = cur_h;
            top_next   = cur_n;
            case (cmd.op)
                OP_FORWARD:
                begin
                    if (in_bounds)
                    begin
                        pos_x_next = nx[PW-1:0];
                        pos_y_next = ny[PW-1:0];
                        res_valid  = 1'b1;
                        res_from_x = to_coord(cur_x);
                        res_from_y = to_coord(cur_y);
                        res_to_x   = to_coord(nx[PW-1:0]);
                        res_to_y   = to_coord(ny[PW-1:0]);
                    end
                end
                OP_TURN_POS:
                begin
                    head_next = (h_plus >= {1'b0, NUM_DIRS}) ? 4'(h_plus - {1'b0, NUM_DIRS})
                                                             : h_plus[3:0];
                end
                OP_TURN_NEG:
                begin
                    head_next = (h_minus >= {1'b0, NUM_DIRS}) ? 4'(h_minus - {1'b0, NUM_DIRS})
                                                              : h_minus[3:0];
                end
                OP_PUSH:
                begin
                    if (is_full)
                    begin
                        res_valid = 1'b1;
                        res_kind  = KIND_OVERFLOW;
                    end
                    else
                    begin
                        top_next = cur_n + CW'(1);
                    end
                end
                OP_POP:
                begin
                    if (is_empty)
                    begin
                        res_valid = 1'b1;
                        res_kind  = KIND_UNDERFLOW;
                    end
                    else
                    begin
                        pos_x_next = tos[EW-1 -: PW];
                        pos_y_next = tos[PW+3 -: PW];
                        head_next  = tos[3:0];
                        top_next   = cur_n - CW'(1);
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_x_reg     <= PW'(RST_START_X) << FRAC_BITS;
            pos_y_reg     <= PW'(RST_START_Y) << FRAC_BITS;
            head_reg      <= RST_START_HEADING;
            top_reg       <= '0;
            tos_sel_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pos_x_reg <= pos_x_next;
            pos_y_reg <= pos_y_next;
            head_reg  <= head_next;
            top_reg   <= top_next;
            if (push_ok)
            begin
                tos_sel_reg <= 1'b0;
            end
            else if (pop_ok)
            begin
                tos_sel_reg <= 1'b1;
            end
            if (exec && res_valid)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            stack_mem[wr_addr] <= cur_entry;
            tos_reg            <= cur_entry;
        end
        if (pop_ok)
        begin
            rd_data_reg <= stack_mem[rd_addr];
        end
        if (exec && res_valid)
        begin
            kind_reg   <= res_kind;
            from_x_reg <= res_from_x;
            from_y_reg <= res_from_y;
            to_x_reg   <= res_to_x;
            to_y_reg   <= res_to_y;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_kind   = kind_reg;
    assign out_from_x = from_x_reg;
    assign out_from_y = from_y_reg;
    assign out_to_x   = to_x_reg;
    assign out_to_y   = to_y_reg;

endmodule

FILE: rtl/core/turtle_path_interpreter.sv
// Turtle path interpreter top level: configuration registers, front end, queue and execution unit.
// Uses tpi_pkg, tpi_front, tpi_queue and tpi_back.
//
// The block takes one L-system command byte per beat and, while its output is not stalled,
// sustains one beat per clock, including runs of pushes and pops, since the top stack entry
// is held in a register and the stack memory needs only one write or one registered read
// per command. A result beat passes through the command queue and then the output
// register. The output register frees its slot as its beat is taken, but a stalled output
// holds the execution unit and fills the two-entry queue before s_axis_tready falls. The
// stack memory needs no clearing pass, because only entries below the current depth are
// ever read.
module turtle_path_interpreter
    import tpi_pkg::*;
#(
    parameter int STACK_DEPTH = 1024,
    parameter int FRAC_BITS   = 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [7:0]            s_axis_tdata,   // [7:0] symbol
    input  logic [0:0]            s_axis_tuser,   // [0] first
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [71:0]           m_axis_tdata,   // [17:0] from_x, [35:18] from_y,
                                                  // [53:36] to_x, [71:54] to_y
    output logic [KIND_W-1:0]     m_axis_tuser,   // [1:0] kind
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int DW    = 8 + FRAC_BITS;
    localparam int PRODW = 23 + FRAC_BITS;

    // Rounded step times cos 30 degrees in position units, ties away from zero.
    function automatic logic [DW-1:0] c30_of(input logic [7:0] step);
        logic [PRODW-1:0] prod;
        logic [PRODW-1:0] rounded;
        prod    = (PRODW'(step) * PRODW'(COS30_Q14)) << FRAC_BITS;
        rounded = prod + PRODW'(1 << (Q14_BITS - 1));
        return rounded[Q14_BITS +: DW];
    endfunction

    cfg_t               cfg_reg;
    logic [DW-1:0]      c30_reg;
    logic               cfg_wr;

    logic               f_valid;
    cmd_t               f_cmd;
    logic               q_ready;
    logic               q_valid;
    cmd_t               q_cmd;
    logic               q_pop;

    logic [COORD_W-1:0] from_x, from_y, to_x, to_y;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.step_length   <= RST_STEP_LENGTH;
            cfg_reg.turn_units    <= RST_TURN_UNITS;
            cfg_reg.start_heading <= RST_START_HEADING;
            cfg_reg.start_x       <= RST_START_X;
            cfg_reg.start_y       <= RST_START_Y;
            cfg_reg.limit_x       <= RST_LIMIT_X;
            cfg_reg.limit_y       <= RST_LIMIT_Y;
            c30_reg               <= c30_of(RST_STEP_LENGTH);
        end
        else if (cfg_wr)
        begin
            case (cfg_index)
                REG_STEP_LENGTH:
                begin
                    cfg_reg.step_length <= cfg_data[7:0];
                    c30_reg             <= c30_of(cfg_data[7:0]);
                end
                REG_TURN_UNITS:    cfg_reg.turn_units    <= mod12(cfg_data[3:0]);
                REG_START_HEADING: cfg_reg.start_heading <= mod12(cfg_data[3:0]);
                REG_START_X:       cfg_reg.start_x       <= cfg_data[9:0];
                REG_START_Y:       cfg_reg.start_y       <= cfg_data[9:0];
                REG_LIMIT_X:       cfg_reg.limit_x       <= cfg_data;
                REG_LIMIT_Y:       cfg_reg.limit_y       <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    tpi_front u_front (
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_first   (s_axis_tuser[0]),
        .in_symbol  (s_axis_tdata),
        .push_valid (f_valid),
        .push_cmd   (f_cmd),
        .push_ready (q_ready)
    );

    tpi_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_cmd    (f_cmd),
        .in_ready  (q_ready),
        .out_valid (q_valid),
        .out_cmd   (q_cmd),
        .out_pop   (q_pop)
    );

    tpi_back #(
        .STACK_DEPTH (STACK_DEPTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .c30        (c30_reg),
        .cmd_valid  (q_valid),
        .cmd        (q_cmd),
        .cmd_pop    (q_pop),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_kind   (m_axis_tuser),
        .out_from_x (from_x),
        .out_from_y (from_y),
        .out_to_x   (to_x),
        .out_to_y   (to_y)
    );

    assign m_axis_tdata = {to_y, to_x, from_y, from_x};

    // Stack warnings carry no coordinates.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser != KIND_SEGMENT) |-> (m_axis_tdata == '0))
        else $error("stack warning beat with nonzero coordinates");

    // A new result beat only follows a command taken from the queue.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(q_valid && q_pop))
        else $error("result beat without an executed command");

    // The input side stalls only while the queue holds commands.
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> q_valid)
        else $error("input stalled with an empty queue");

endmodule

FILE: tb/sv/tb_turtle_path_interpreter.sv
`timescale 1ns / 1ps
// Self-checking testbench of turtle_path_interpreter: directed, deep-stack and random L-system runs.
// A scripted driver and a stalling monitor check every result beat against a turtle predictor.
// Depends on tpi_pkg and the turtle_path_interpreter RTL.
module tb_turtle_path_interpreter;
    import tpi_pkg::*;

    localparam int     STACK_DEPTH   = 1024;
    localparam int     FRAC_BITS     = 8;
    localparam int     SETTLE_CYCLES = 8;
    localparam longint TIMEOUT_NS    = 64'd20_000_000;
    localparam int     PRINT_CAP     = 40;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

    typedef enum logic [1:0] {STEP_SYMBOL, STEP_WRITE, STEP_DRAIN} script_op_t;

    typedef struct {
        script_op_t            op;
        logic                  first;
        logic [SYMBOL_W-1:0]   symbol;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
    } script_entry_t;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [COORD_W-1:0] fx;
        logic [COORD_W-1:0] fy;
        logic [COORD_W-1:0] tx;
        logic [COORD_W-1:0] ty;
    } path_event_t;

    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata  = '0;
    logic [0:0]            s_axis_tuser  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [71:0]           m_axis_tdata;
    logic [KIND_W-1:0]     m_axis_tuser;
    logic                  cfg_valid     = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index     = '0;
    logic [CFG_DATA_W-1:0] cfg_data      = '0;

    script_entry_t cmd_script[$];
    path_event_t   pending_marks[$];

    logic [7:0]  step_len;
    logic [3:0]  turn_amt;
    logic [3:0]  home_dir;
    logic [9:0]  home_x;
    logic [9:0]  home_y;
    logic [10:0] scr_w;
    logic [10:0] scr_h;

    longint turtle_x;
    longint turtle_y;
    int     turtle_dir;
    int     nest_depth;
    longint saved_x   [STACK_DEPTH];
    longint saved_y   [STACK_DEPTH];
    int     saved_dir [STACK_DEPTH];

    int n_symbols, n_writes, n_beats, n_segments, n_overflows, n_underflows, n_errors;
    int gap_left, burst_left, settle_left;
    int rx_mode, rx_mode_left, rx_stall;
    int random_cmds;

    turtle_path_interpreter #(
        .STACK_DEPTH (STACK_DEPTH),
        .FRAC_BITS   (FRAC_BITS)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #10 clk = ~clk;

    task automatic report_mismatch(input string msg);
        if (n_errors < PRINT_CAP)
        begin
            $display("[%0t] mismatch: %s", $time, msg);
        end
        n_errors++;
    endtask

    function automatic int cos_q14(input int k);
        case (k)
            0:       return 1 << Q14_BITS;
            1:       return COS30_Q14;
            2:       return 1 << (Q14_BITS - 1);
            4:       return -(1 << (Q14_BITS - 1));
            5:       return -COS30_Q14;
            6:       return -(1 << Q14_BITS);
            7:       return -COS30_Q14;
            8:       return -(1 << (Q14_BITS - 1));
            10:      return 1 << (Q14_BITS - 1);
            11:      return COS30_Q14;
            default: return 0;
        endcase
    endfunction

    // Step length times a Q2.14 factor, scaled to the position format, ties away from zero.
    function automatic longint scaled_step(input int trig);
        longint p;
        longint mag;
        longint r;
        p   = longint'(step_len) * trig;
        mag = (p < 0) ? -p : p;
        r   = ((mag << FRAC_BITS) + (longint'(1) << (Q14_BITS - 1))) >>> Q14_BITS;
        return (p < 0) ? -r : r;
    endfunction

    task automatic send_home();
        turtle_x   = longint'(home_x) << FRAC_BITS;
        turtle_y   = longint'(home_y) << FRAC_BITS;
        turtle_dir = int'(home_dir) % int'(NUM_DIRS);
        nest_depth = 0;
    endtask

    task automatic interpret_symbol(input logic first, input logic [SYMBOL_W-1:0] sym);
        longint      nx;
        longint      ny;
        longint      bw;
        longint      bh;
        path_event_t mark;
        mark = '0;
        if (first)
        begin
            send_home();
        end
        case (sym)
            SYM_FORWARD:
            begin
                nx = turtle_x + scaled_step(cos_q14(turtle_dir));
                ny = turtle_y + scaled_step(cos_q14((turtle_dir + int'(SIN_OFFSET))
                                                    % int'(NUM_DIRS)));
                bw = longint'((scr_w > POS_LIMIT) ? POS_LIMIT : scr_w) << FRAC_BITS;
                bh = longint'((scr_h > POS_LIMIT) ? POS_LIMIT : scr_h) << FRAC_BITS;
                if (nx >= 0 && nx < bw && ny >= 0 && ny < bh)
                begin
                    mark.kind = KIND_SEGMENT;
                    mark.fx   = turtle_x[COORD_W-1:0];
                    mark.fy   = turtle_y[COORD_W-1:0];
                    mark.tx   = nx[COORD_W-1:0];
                    mark.ty   = ny[COORD_W-1:0];
                    pending_marks.push_back(mark);
                    turtle_x = nx;
                    turtle_y = ny;
                end
            end
            SYM_PLUS:
            begin
                turtle_dir = (turtle_dir + int'(turn_amt)) % int'(NUM_DIRS);
            end
            SYM_MINUS:
            begin
                turtle_dir = (turtle_dir + int'(NUM_DIRS) - (int'(turn_amt) % int'(NUM_DIRS)))
                             % int'(NUM_DIRS);
            end
            SYM_PUSH:
            begin
                if (nest_depth >= STACK_DEPTH)
                begin
                    mark.kind = KIND_OVERFLOW;
                    pending_marks.push_back(mark);
                end
                else
                begin
                    saved_x[nest_depth]   = turtle_x;
                    saved_y[nest_depth]   = turtle_y;
                    saved_dir[nest_depth] = turtle_dir;
                    nest_depth++;
                end
            end
            SYM_POP:
            begin
                if (nest_depth == 0)
                begin
                    mark.kind = KIND_UNDERFLOW;
                    pending_marks.push_back(mark);
                end
                else
                begin
                    nest_depth--;
                    turtle_x   = saved_x[nest_depth];
                    turtle_y   = saved_y[nest_depth];
                    turtle_dir = saved_dir[nest_depth] % int'(NUM_DIRS);
                end
            end
            default: ;
        endcase
    endtask

    task automatic push_symbol(input logic first, input logic [SYMBOL_W-1:0] sym);
        script_entry_t e;
        e = '{op: STEP_SYMBOL, first: first, symbol: sym, idx: '0, data: '0};
        cmd_script.push_back(e);
    endtask

    task automatic push_write(input logic [CFG_IDX_W-1:0] idx, input int value);
        script_entry_t e;
        e = '{op: STEP_WRITE, first: 1'b0, symbol: '0, idx: idx, data: value[CFG_DATA_W-1:0]};
        cmd_script.push_back(e);
    endtask

    task automatic setup_screen(input int stp, input int trn, input int hd, input int sx,
                                input int sy, input int w, input int h);
        script_entry_t e;
        e = '{op: STEP_DRAIN, first: 1'b0, symbol: '0, idx: '0, data: '0};
        cmd_script.push_back(e);
        push_write(REG_STEP_LENGTH, stp);
        push_write(REG_TURN_UNITS, trn);
        push_write(REG_START_HEADING, hd);
        push_write(REG_START_X, sx);
        push_write(REG_START_Y, sy);
        push_write(REG_LIMIT_X, w);
        push_write(REG_LIMIT_Y, h);
    endtask

    // Mostly balanced bracket sequences; some stray pops, noise bytes and restarts.
    task automatic add_lsys_run(input int n);
        int   depth;
        int   done;
        int   r;
        logic [SYMBOL_W-1:0] noise;
        depth = 0;
        done  = 0;
        push_symbol(1'b1, SYM_FORWARD);
        while (done < n)
        begin
            r = $urandom_range(0, 99);
            if (r < 40)
            begin
                push_symbol(1'b0, SYM_FORWARD);
                done++;
            end
            else if (r < 54)
            begin
                push_symbol(1'b0, SYM_PLUS);
                done++;
            end
            else if (r < 68)
            begin
                push_symbol(1'b0, SYM_MINUS);
                done++;
            end
            else if (r < 80)
            begin
                push_symbol(1'b0, SYM_PUSH);
                depth++;
                done++;
            end
            else if (r < 90)
            begin
                if (depth > 0 || $urandom_range(0, 4) == 0)
                begin
                    push_symbol(1'b0, SYM_POP);
                    if (depth > 0)
                    begin
                        depth--;
                    end
                    done++;
                end
            end
            else if (r < 97)
            begin
                noise = SYMBOL_W'($urandom_range(0, 255));
                push_symbol(1'($urandom_range(0, 1)), noise);
            end
            else
            begin
                push_symbol(1'b1, $urandom_range(0, 1) ? SYM_FORWARD : SYM_PUSH);
                depth = 0;
                done++;
            end
        end
        random_cmds += done;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : tx_side
        logic nv;
        logic ncv;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= '0;
            cfg_valid     <= 1'b0;
            cfg_index     <= '0;
            cfg_data      <= '0;
            step_len      = RST_STEP_LENGTH;
            turn_amt      = RST_TURN_UNITS;
            home_dir      = RST_START_HEADING;
            home_x        = RST_START_X;
            home_y        = RST_START_Y;
            scr_w         = RST_LIMIT_X;
            scr_h         = RST_LIMIT_Y;
            send_home();
            gap_left      = 0;
            burst_left    = $urandom_range(1, 30);
            settle_left   = SETTLE_CYCLES;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                interpret_symbol(s_axis_tuser[0], s_axis_tdata);
                n_symbols++;
            end
            if (cfg_valid && cfg_ready)
            begin
                n_writes++;
                case (cfg_index)
                    REG_STEP_LENGTH:   step_len = cfg_data[7:0];
                    REG_TURN_UNITS:    turn_amt = cfg_data[3:0];
                    REG_START_HEADING: home_dir = cfg_data[3:0];
                    REG_START_X:       home_x   = cfg_data[9:0];
                    REG_START_Y:       home_y   = cfg_data[9:0];
                    REG_LIMIT_X:       scr_w    = cfg_data[10:0];
                    REG_LIMIT_Y:       scr_h    = cfg_data[10:0];
                    default: ;
                endcase
            end
            nv  = 1'b0;
            ncv = 1'b0;
            if (s_axis_tvalid && !s_axis_tready)
            begin
                nv = 1'b1;
            end
            else if (cfg_valid && !cfg_ready)
            begin
                ncv = 1'b1;
            end
            else if (gap_left > 0)
            begin
                gap_left--;
            end
            else if (cmd_script.size() != 0)
            begin
                case (cmd_script[0].op)
                    STEP_SYMBOL:
                    begin
                        nv = 1'b1;
                        s_axis_tdata <= cmd_script[0].symbol;
                        s_axis_tuser <= cmd_script[0].first;
                        void'(cmd_script.pop_front());
                        burst_left--;
                        if (burst_left <= 0)
                        begin
                            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 300)
                                                                     : $urandom_range(1, 30);
                            gap_left   = $urandom_range(0, 8);
                        end
                    end
                    STEP_WRITE:
                    begin
                        ncv = 1'b1;
                        cfg_index <= cmd_script[0].idx;
                        cfg_data  <= cmd_script[0].data;
                        void'(cmd_script.pop_front());
                    end
                    default:
                    begin
                        if (pending_marks.size() != 0)
                        begin
                            settle_left = SETTLE_CYCLES;
                        end
                        else if (settle_left > 0)
                        begin
                            settle_left--;
                        end
                        else
                        begin
                            void'(cmd_script.pop_front());
                            settle_left = SETTLE_CYCLES;
                        end
                    end
                endcase
            end
            s_axis_tvalid <= nv;
            cfg_valid     <= ncv;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : rx_side
        path_event_t got;
        path_event_t want;
        logic        rdy;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            rx_mode      = 0;
            rx_mode_left = 0;
            rx_stall     = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.kind = m_axis_tuser;
                got.fx   = m_axis_tdata[17:0];
                got.fy   = m_axis_tdata[35:18];
                got.tx   = m_axis_tdata[53:36];
                got.ty   = m_axis_tdata[71:54];
                n_beats++;
                if (pending_marks.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected beat %0d, kind %0d", n_beats, got.kind));
                end
                else
                begin
                    want = pending_marks.pop_front();
                    if (got.kind !== want.kind)
                        report_mismatch($sformatf("beat %0d kind %0d, expected %0d",
                                                  n_beats, got.kind, want.kind));
                    if (got.fx !== want.fx)
                        report_mismatch($sformatf("beat %0d from_x %h, expected %h",
                                                  n_beats, got.fx, want.fx));
                    if (got.fy !== want.fy)
                        report_mismatch($sformatf("beat %0d from_y %h, expected %h",
                                                  n_beats, got.fy, want.fy));
                    if (got.tx !== want.tx)
                        report_mismatch($sformatf("beat %0d to_x %h, expected %h",
                                                  n_beats, got.tx, want.tx));
                    if (got.ty !== want.ty)
                        report_mismatch($sformatf("beat %0d to_y %h, expected %h",
                                                  n_beats, got.ty, want.ty));
                    case (want.kind)
                        KIND_SEGMENT:  n_segments++;
                        KIND_OVERFLOW: n_overflows++;
                        default:       n_underflows++;
                    endcase
                end
            end
            if (rx_mode_left == 0)
            begin
                rx_mode      = $urandom_range(0, 2);
                rx_mode_left = $urandom_range(50, 400);
            end
            else
            begin
                rx_mode_left--;
            end
            if (rx_mode == 0)
            begin
                rdy = 1'b1;
            end
            else if (rx_mode == 1)
            begin
                rdy = 1'($urandom_range(0, 1));
            end
            else if (rx_stall > 0)
            begin
                rx_stall--;
                rdy = 1'b0;
            end
            else if ($urandom_range(0, 7) == 0)
            begin
                rx_stall = $urandom_range(1, 16);
                rdy = 1'b0;
            end
            else
            begin
                rdy = 1'b1;
            end
            m_axis_tready <= rdy;
        end
    end

    initial
    begin
        int i;
        int r;
        int stp;
        int trn;
        int hd;
        int sx;
        int sy;
        int w;
        int h;
        int junk;

        // Reset register values: plain steps, turns, bracket restore, stray pop, homing.
        push_symbol(1'b0, SYM_FORWARD);
        push_symbol(1'b0, SYM_FORWARD);
        push_symbol(1'b0, SYM_PLUS);
        push_symbol(1'b0, SYM_FORWARD);
        push_symbol(1'b0, SYM_MINUS);
        push_symbol(1'b0, SYM_MINUS);
        push_symbol(1'b0, SYM_FORWARD);
        push_symbol(1'b0, SYM_PUSH);
        push_symbol(1'b0, SYM_FORWARD);
        push_symbol(1'b0, SYM_PLUS);
        push_symbol(1'b0, SYM_POP);
        push_symbol(1'b0, SYM_FORWARD);
        push_symbol(1'b0, SYM_POP);
        push_symbol(1'b0, 8'h00);
        push_symbol(1'b0, 8'hFF);
        push_symbol(1'b1, 8'hA5);
        push_symbol(1'b0, SYM_PUSH);
        push_symbol(1'b1, SYM_POP);
        push_symbol(1'b1, SYM_FORWARD);
        push_symbol(1'b0, 8'h66);
        for (i = 0; i < 4; i++)
        begin
            push_symbol(1'b0, SYM_MINUS);
        end
        push_symbol(1'b0, SYM_FORWARD);

        setup_screen(255, 15, 15, 1023, 1023, 2047, 2047);
        push_symbol(1'b1, SYM_FORWARD);
        for (i = 0; i < 4; i++)
        begin
            push_symbol(1'b0, SYM_PLUS);
            push_symbol(1'b0, SYM_FORWARD);
        end
        push_symbol(1'b0, SYM_PUSH);
        push_symbol(1'b0, SYM_MINUS);
        push_symbol(1'b0, SYM_FORWARD);
        push_symbol(1'b0, SYM_POP);
        push_symbol(1'b0, SYM_FORWARD);

        setup_screen(0, 0, 0, 0, 0, 0, 0);
        push_symbol(1'b1, SYM_FORWARD);
        push_symbol(1'b0, SYM_PLUS);
        push_symbol(1'b0, SYM_MINUS);
        push_symbol(1'b0, SYM_PUSH);
        push_symbol(1'b0, SYM_FORWARD);
        push_symbol(1'b0, SYM_POP);
        push_symbol(1'b0, SYM_POP);

        setup_screen(255, 11, 0, 0, 0, 1024, 1024);
        push_symbol(1'b1, SYM_FORWARD);
        for (i = 0; i < 4; i++)
        begin
            push_symbol(1'b0, SYM_FORWARD);
        end
        push_symbol(1'b0, SYM_PLUS);
        push_symbol(1'b0, SYM_FORWARD);
        push_symbol(1'b0, SYM_MINUS);
        push_symbol(1'b0, SYM_MINUS);
        push_symbol(1'b0, SYM_FORWARD);

        setup_screen(1, 12, 11, 1023, 0, 1, 1);
        push_symbol(1'b1, SYM_FORWARD);
        push_symbol(1'b0, SYM_PLUS);
        push_symbol(1'b0, SYM_FORWARD);
        push_symbol(1'b1, SYM_MINUS);
        push_symbol(1'b0, SYM_FORWARD);

        // Fill the stack past its depth, then unwind part of it.
        setup_screen(2, 1, 0, 512, 512, 1024, 1024);
        push_symbol(1'b1, SYM_PUSH);
        for (i = 1; i < STACK_DEPTH + 2; i++)
        begin
            if ($urandom_range(0, 5) == 0)
            begin
                push_symbol(1'b0, $urandom_range(0, 1) ? SYM_FORWARD : SYM_PLUS);
            end
            push_symbol(1'b0, SYM_PUSH);
        end
        for (i = 0; i < 64; i++)
        begin
            if ($urandom_range(0, 5) == 0)
            begin
                push_symbol(1'b0, SYM_FORWARD);
            end
            push_symbol(1'b0, SYM_POP);
        end

        random_cmds = 0;
        while (random_cmds < 600)
        begin
            r   = $urandom_range(0, 9);
            stp = (r < 6) ? $urandom_range(1, 12) : (r < 8) ? $urandom_range(0, 255)
                                                            : $urandom_range(13, 40);
            trn = $urandom_range(0, 15);
            hd  = $urandom_range(0, 15);
            sx  = $urandom_range(0, 1) ? $urandom_range(200, 800) : $urandom_range(0, 1023);
            sy  = $urandom_range(0, 1) ? $urandom_range(200, 800) : $urandom_range(0, 1023);
            r   = $urandom_range(0, 7);
            w   = (r == 0) ? $urandom_range(0, 2047) : (r == 1) ? 1024 : (r == 2) ? 2047
                                                                   : $urandom_range(300, 1024);
            r   = $urandom_range(0, 7);
            h   = (r == 0) ? $urandom_range(0, 2047) : (r == 1) ? 1024 : (r == 2) ? 2047
                                                                   : $urandom_range(300, 1024);
            // Upper data bits beyond a register's width must be ignored.
            junk = $urandom_range(0, 1) ? $urandom : 0;
            setup_screen(stp | (junk & 'h700), trn | (junk & 'h7F0), hd | (junk & 'h7F0),
                         sx | (junk & 'h400), sy | (junk & 'h400), w, h);
            if ($urandom_range(0, 3) == 0)
            begin
                push_write(REG_SPARE, $urandom_range(0, 2047));
            end
            add_lsys_run($urandom_range(60, 250));
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        while (cmd_script.size() != 0 || s_axis_tvalid || cfg_valid || pending_marks.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (pending_marks.size() != 0)
        begin
            report_mismatch($sformatf("%0d expected beats never arrived", pending_marks.size()));
        end

        $display("Sent %0d command beats across %0d register writes, stack runs and random paths.",
                 n_symbols, n_writes);
        $display("Checked %0d result beats: %0d segments, %0d overflows, %0d underflows.",
                 n_beats, n_segments, n_overflows, n_underflows);
        if (n_errors == 0)
        begin
            $display("tb_turtle_path_interpreter passed");
        end
        else
        begin
            $display("tb_turtle_path_interpreter failed");
        end
        $finish;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("tb_turtle_path_interpreter failed");
        $finish;
    end

endmodule
